// ----- rtl/mono_page_framebuffer_draw_top_defines.svh -----
// Assertion macros shared by the frame buffer modules.
// Each use expects clk and rst_n in scope.
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_TOP_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MPFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MPFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MPFB_ASSERT(lbl, prop, msg)
`define MPFB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/mpfb_pkg.sv -----
package mpfb_pkg;

    localparam int unsigned SCREEN_COLUMNS_DEF = 128;
    localparam int unsigned SCREEN_PAGES_DEF   = 8;

    // Wide enough for start plus extent minus one
    localparam int unsigned COORD_W = 10;
    typedef logic [COORD_W-1:0] coord_t;

    localparam logic [2:0] CMD_PIXEL_WRITE = 3'd0;
    localparam logic [2:0] CMD_PIXEL_READ  = 3'd1;
    localparam logic [2:0] CMD_LINE        = 3'd2;
    localparam logic [2:0] CMD_RECT        = 3'd3;
    localparam logic [2:0] CMD_CLEAR       = 3'd4;
    localparam logic [2:0] CMD_READ_BYTE   = 3'd5;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Outline segments: top, right, bottom, left
    localparam logic [1:0] SEG_TOP    = 2'd0;
    localparam logic [1:0] SEG_RIGHT  = 2'd1;
    localparam logic [1:0] SEG_BOTTOM = 2'd2;
    localparam logic [1:0] SEG_LEFT   = 2'd3;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] x_coord;
        logic [7:0] y_coord;
        logic [7:0] x_second;
        logic [7:0] y_second;
        logic       pixel_value;
    } req_t;

    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
    } rsp_t;

endpackage

// ----- rtl/mpfb_store.sv -----
`include "mono_page_framebuffer_draw_top_defines.svh"

module mpfb_store #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] addr,
    input  logic              wr_en,
    input  logic [7:0]        wr_data,
    output logic [7:0]        rd_data,
    output logic              clr_busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // Sweep zeros after reset, then take the write port
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= 8'h00;
        end
        else if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

    `MPFB_ASSERT(a_no_write_while_clearing, !(clr_busy_reg && wr_en), "write during clear pass")
    `MPFB_ASSERT(a_clear_ends_at_last, $fell(clr_busy_reg) |-> ($past(clr_cnt_reg) == LAST_ADDR), "clear pass ended early")

endmodule

// ----- rtl/mpfb_seq.sv -----
`include "mono_page_framebuffer_draw_top_defines.svh"

module mpfb_seq #(
    parameter int unsigned COLS   = 128,
    parameter int unsigned PAGES  = 8,
    parameter int unsigned ADDR_W = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  mpfb_pkg::req_t    req,
    output logic              res_valid,
    input  logic              res_ready,
    output mpfb_pkg::rsp_t    res,
    input  logic              clr_busy,
    output logic [ADDR_W-1:0] mem_addr,
    output logic              mem_wr_en,
    output logic [7:0]        mem_wr_data,
    input  logic [7:0]        mem_rd_data
);

    localparam int unsigned ROWS  = 8 * PAGES;
    localparam int unsigned DEPTH = COLS * PAGES;
    localparam int unsigned COL_W = $clog2(COLS);
    localparam int unsigned ROW_W = $clog2(ROWS);

    localparam mpfb_pkg::coord_t COL_LAST  = mpfb_pkg::coord_t'(COLS - 1);
    localparam mpfb_pkg::coord_t ROW_LAST  = mpfb_pkg::coord_t'(ROWS - 1);
    localparam mpfb_pkg::coord_t COL_LIMIT = mpfb_pkg::coord_t'(COLS);
    localparam mpfb_pkg::coord_t ROW_LIMIT = mpfb_pkg::coord_t'(ROWS);
    localparam mpfb_pkg::coord_t PG_LIMIT  = mpfb_pkg::coord_t'(PAGES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_WRITE,
        S_DONE
    } state_t;

    state_t           state_reg;
    mpfb_pkg::req_t   item_reg;
    mpfb_pkg::rsp_t   res_reg;
    logic [1:0]       seg_idx_reg;
    logic [COL_W-1:0] cur_col_reg;
    logic [COL_W-1:0] col_end_reg;
    logic [ROW_W-1:0] cur_row_reg;
    logic [ROW_W-1:0] row_start_reg;
    logic [ROW_W-1:0] row_end_reg;

    mpfb_pkg::coord_t xa, ya, xb, yb, xe, ye, ya8;
    mpfb_pkg::coord_t c0, c1, r0, r1, c1_clip, r1_clip;
    logic             reject;
    logic             empty_seg;
    logic             zero_size;
    logic             last_seg;
    logic             is_read;
    logic             lit;
    logic [7:0]       bit_mask;
    logic             bit_val;
    logic [ADDR_W-1:0] col_ext;
    logic [ADDR_W-1:0] page_ext;

    // Segment bounds for the current command and outline segment
    always_comb
    begin
        xa        = mpfb_pkg::coord_t'(item_reg.x_coord);
        ya        = mpfb_pkg::coord_t'(item_reg.y_coord);
        xb        = mpfb_pkg::coord_t'(item_reg.x_second);
        yb        = mpfb_pkg::coord_t'(item_reg.y_second);
        xe        = xa + xb - mpfb_pkg::coord_t'(1);
        ye        = ya + yb - mpfb_pkg::coord_t'(1);
        ya8       = mpfb_pkg::coord_t'({item_reg.y_coord, 3'b000});
        zero_size = (xb == '0) || (yb == '0);
        c0        = xa;
        c1        = xa;
        r0        = ya;
        r1        = ya;
        reject    = 1'b0;
        empty_seg = 1'b0;
        case (item_reg.cmd)
            mpfb_pkg::CMD_PIXEL_WRITE, mpfb_pkg::CMD_PIXEL_READ:
            begin
                reject = !((xa < COL_LIMIT) && (ya < ROW_LIMIT));
            end
            mpfb_pkg::CMD_READ_BYTE:
            begin
                reject = !((xa < COL_LIMIT) && (ya < PG_LIMIT));
                r0     = ya8;
                r1     = ya8;
            end
            mpfb_pkg::CMD_LINE:
            begin
                if (xa == xb)
                begin
                    r1 = yb;
                end
                else if (ya == yb)
                begin
                    c1 = xb;
                end
                else
                begin
                    reject = 1'b1;
                end
            end
            mpfb_pkg::CMD_RECT:
            begin
                empty_seg = zero_size;
                case (seg_idx_reg)
                    mpfb_pkg::SEG_TOP:
                    begin
                        c1 = xe;
                    end
                    mpfb_pkg::SEG_RIGHT:
                    begin
                        c0 = xe;
                        c1 = xe;
                        r1 = ye;
                    end
                    mpfb_pkg::SEG_BOTTOM:
                    begin
                        c1 = xe;
                        r0 = ye;
                        r1 = ye;
                    end
                    default:
                    begin
                        r1 = ye;
                    end
                endcase
            end
            mpfb_pkg::CMD_CLEAR:
            begin
                empty_seg = zero_size;
                c1        = xe;
                r1        = ye;
            end
            default:
            begin
                reject = 1'b1;
            end
        endcase
        c1_clip   = (c1 > COL_LAST) ? COL_LAST : c1;
        r1_clip   = (r1 > ROW_LAST) ? ROW_LAST : r1;
        empty_seg = empty_seg || (c0 > c1_clip) || (r0 > r1_clip);
        last_seg  = (item_reg.cmd != mpfb_pkg::CMD_RECT) || (seg_idx_reg == mpfb_pkg::SEG_LEFT);
    end

    assign is_read  = (item_reg.cmd == mpfb_pkg::CMD_PIXEL_READ) ||
                      (item_reg.cmd == mpfb_pkg::CMD_READ_BYTE);
    assign lit      = (item_reg.cmd == mpfb_pkg::CMD_CLEAR) ? 1'b0 : item_reg.pixel_value;
    assign bit_mask = 8'b0000_0001 << cur_row_reg[2:0];
    assign bit_val  = |(mem_rd_data & bit_mask);

    assign col_ext  = ADDR_W'(cur_col_reg);
    assign page_ext = ADDR_W'(cur_row_reg >> 3);
    assign mem_addr = ADDR_W'(col_ext * ADDR_W'(PAGES)) + page_ext;

    assign mem_wr_en   = (state_reg == S_WRITE) && !is_read;
    assign mem_wr_data = lit ? (mem_rd_data | bit_mask) : (mem_rd_data & ~bit_mask);

    assign req_ready = (state_reg == S_IDLE) && !clr_busy;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_idx_reg   <= '0;
            item_reg      <= '0;
            res_reg       <= '0;
            cur_col_reg   <= '0;
            col_end_reg   <= '0;
            cur_row_reg   <= '0;
            row_start_reg <= '0;
            row_end_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        item_reg    <= req;
                        seg_idx_reg <= '0;
                        state_reg   <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    if (reject)
                    begin
                        res_reg   <= '{status: mpfb_pkg::STATUS_REJECT, read_data: 8'h00};
                        state_reg <= S_DONE;
                    end
                    else if (empty_seg)
                    begin
                        if (last_seg)
                        begin
                            res_reg   <= '{status: mpfb_pkg::STATUS_DONE, read_data: 8'h00};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            seg_idx_reg <= seg_idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cur_col_reg   <= COL_W'(c0);
                        col_end_reg   <= COL_W'(c1_clip);
                        cur_row_reg   <= ROW_W'(r0);
                        row_start_reg <= ROW_W'(r0);
                        row_end_reg   <= ROW_W'(r1_clip);
                        state_reg     <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (is_read)
                    begin
                        res_reg.status    <= mpfb_pkg::STATUS_DONE;
                        res_reg.read_data <= (item_reg.cmd == mpfb_pkg::CMD_READ_BYTE)
                                             ? mem_rd_data : {7'b0, bit_val};
                        state_reg         <= S_DONE;
                    end
                    else if (cur_row_reg != row_end_reg)
                    begin
                        cur_row_reg <= cur_row_reg + 1'b1;
                        state_reg   <= S_READ;
                    end
                    else if (cur_col_reg != col_end_reg)
                    begin
                        cur_col_reg <= cur_col_reg + 1'b1;
                        cur_row_reg <= row_start_reg;
                        state_reg   <= S_READ;
                    end
                    else if (last_seg)
                    begin
                        res_reg   <= '{status: mpfb_pkg::STATUS_DONE, read_data: 8'h00};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        seg_idx_reg <= seg_idx_reg + 1'b1;
                        state_reg   <= S_SETUP;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `MPFB_ASSERT_NEXT(a_res_holds, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")
    `MPFB_ASSERT(a_wr_in_range, mem_wr_en |-> (mem_addr <= ADDR_W'(DEPTH - 1)), "write address off store")
    `MPFB_ASSERT(a_read_no_write, mem_wr_en |-> (item_reg.cmd != mpfb_pkg::CMD_PIXEL_READ && item_reg.cmd != mpfb_pkg::CMD_READ_BYTE), "read command wrote store")

endmodule

// ----- rtl/mono_page_framebuffer_draw_top.sv -----
// Flow: a setup step per segment (four for an outline, else one), then a read and a write
//   of its page byte per pixel touched, then a move into the output register; a point
//   command passes setup, read, write and done before rsp_valid rises.
// Order: one command at a time; the next beat is taken once the sequencer is back in idle
//   after its result leaves for the output register.
// Reset: zeroes the store one byte a cycle (all 1024 bytes by default) with req_ready low.
module mono_page_framebuffer_draw_top #(
    parameter int unsigned SCREEN_COLUMNS = mpfb_pkg::SCREEN_COLUMNS_DEF,
    parameter int unsigned SCREEN_PAGES   = mpfb_pkg::SCREEN_PAGES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mpfb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mpfb_pkg::rsp_t rsp
);

    localparam int unsigned DEPTH  = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic              res_valid;
    logic              res_ready;
    mpfb_pkg::rsp_t    res;
    logic              clr_busy;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_wr_en;
    logic [7:0]        mem_wr_data;
    logic [7:0]        mem_rd_data;
    logic              rsp_valid_reg;
    mpfb_pkg::rsp_t    rsp_reg;

    mpfb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .addr     (mem_addr),
        .wr_en    (mem_wr_en),
        .wr_data  (mem_wr_data),
        .rd_data  (mem_rd_data),
        .clr_busy (clr_busy)
    );

    mpfb_seq #(
        .COLS   (SCREEN_COLUMNS),
        .PAGES  (SCREEN_PAGES),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .clr_busy    (clr_busy),
        .mem_addr    (mem_addr),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

    // Output stage: take a new beat when empty or draining
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
            rsp_reg       <= res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- dv/tb_mono_page_framebuffer_draw_top.sv -----
module tb_mono_page_framebuffer_draw_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS     = mpfb_pkg::SCREEN_COLUMNS_DEF;
    localparam int PAGES    = mpfb_pkg::SCREEN_PAGES_DEF;
    localparam int ROWS     = 8 * PAGES;
    localparam int LAST_COL = COLS - 1;
    localparam int LAST_ROW = ROWS - 1;

    // Codes the block does not implement
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // A full-screen clear visits every pixel with no beat in between
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_CHUNKS  = 15;
    localparam int CHUNK_ITEMS    = 50;
    localparam int MAX_REPORTS    = 20;

    typedef struct {
        mpfb_pkg::req_t cmd;
        mpfb_pkg::rsp_t want;
    } pending_t;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    mpfb_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    mpfb_pkg::rsp_t rsp;

    logic [7:0] fb_model [COLS*PAGES];
    pending_t   pending_results [$];

    int errors      = 0;
    int sent        = 0;
    int checked     = 0;
    int idle_cycles = 0;
    int ready_hold  = 0;
    int cmd_count [8] = '{default: 0};
    bit no_stall    = 1'b0;
    int wx          = 0;
    int wy          = 0;

    mono_page_framebuffer_draw_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- frame model

    function automatic void model_plot(int col, int row, bit lit);
        int idx;
        if (col >= COLS || row >= ROWS)
            return;
        idx = col * PAGES + row / 8;
        fb_model[idx][row % 8] = lit;
    endfunction

    function automatic void model_hline(int c0, int c1, int row, bit lit);
        for (int c = c0; c <= c1 && c < COLS; c++)
            model_plot(c, row, lit);
    endfunction

    function automatic void model_vline(int col, int r0, int r1, bit lit);
        for (int r = r0; r <= r1 && r < ROWS; r++)
            model_plot(col, r, lit);
    endfunction

    function automatic mpfb_pkg::rsp_t predict_command(mpfb_pkg::req_t c);
        mpfb_pkg::rsp_t r;
        int             xa, ya, xb, yb, xe, ye;
        xa = int'(c.x_coord);
        ya = int'(c.y_coord);
        xb = int'(c.x_second);
        yb = int'(c.y_second);
        r.status    = mpfb_pkg::STATUS_DONE;
        r.read_data = '0;
        case (c.cmd)
            mpfb_pkg::CMD_PIXEL_WRITE:
                if (xa < COLS && ya < ROWS)
                    model_plot(xa, ya, c.pixel_value);
                else
                    r.status = mpfb_pkg::STATUS_REJECT;
            mpfb_pkg::CMD_PIXEL_READ:
                if (xa < COLS && ya < ROWS)
                    r.read_data = {7'd0, fb_model[xa*PAGES + ya/8][ya % 8]};
                else
                    r.status = mpfb_pkg::STATUS_REJECT;
            mpfb_pkg::CMD_LINE:
                if (xa == xb)
                    model_vline(xa, ya, yb, c.pixel_value);
                else if (ya == yb)
                    model_hline(xa, xb, ya, c.pixel_value);
                else
                    r.status = mpfb_pkg::STATUS_REJECT;
            mpfb_pkg::CMD_RECT:
                if (xb != 0 && yb != 0)
                begin
                    xe = xa + xb - 1;
                    ye = ya + yb - 1;
                    model_hline(xa, xe, ya, c.pixel_value);
                    model_vline(xe, ya, ye, c.pixel_value);
                    model_hline(xa, xe, ye, c.pixel_value);
                    model_vline(xa, ya, ye, c.pixel_value);
                end
            mpfb_pkg::CMD_CLEAR:
                if (xb != 0 && yb != 0)
                begin
                    for (int col = xa; col < xa + xb && col < COLS; col++)
                        model_vline(col, ya, ya + yb - 1, 1'b0);
                end
            mpfb_pkg::CMD_READ_BYTE:
                if (xa < COLS && ya < PAGES)
                    r.read_data = fb_model[xa*PAGES + ya];
                else
                    r.status = mpfb_pkg::STATUS_REJECT;
            default:
                r.status = mpfb_pkg::STATUS_REJECT;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Bias toward a small window so that draws and reads overlap
    function automatic int pick_coord(int limit, int base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return base + $urandom_range(0, 15);
        if (r < 85)
            return $urandom_range(0, limit - 1);
        return $urandom_range(0, 255);
    endfunction

    // Keep most extents short so the run stays brief
    function automatic int pick_extent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return $urandom_range(0, 8);
        if (r < 97)
            return $urandom_range(9, 40);
        return $urandom_range(0, 255);
    endfunction

    function automatic mpfb_pkg::req_t make_cmd(logic [2:0] op, int x, int y,
                                                int x2, int y2, logic lit);
        mpfb_pkg::req_t c;
        c.cmd         = op;
        c.x_coord     = 8'(x);
        c.y_coord     = 8'(y);
        c.x_second    = 8'(x2);
        c.y_second    = 8'(y2);
        c.pixel_value = lit;
        return c;
    endfunction

    function automatic mpfb_pkg::req_t random_command();
        mpfb_pkg::req_t c;
        int             r;
        int             pick;
        c.x_coord     = 8'(pick_coord(COLS, wx));
        c.y_coord     = 8'(pick_coord(ROWS, wy));
        c.x_second    = 8'(pick_extent());
        c.y_second    = 8'(pick_extent());
        c.pixel_value = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 20)
            c.cmd = mpfb_pkg::CMD_PIXEL_WRITE;
        else if (r < 35)
            c.cmd = mpfb_pkg::CMD_PIXEL_READ;
        else if (r < 55)
        begin
            c.cmd = mpfb_pkg::CMD_LINE;
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                c.y_second = c.y_coord;
                if ($urandom_range(0, 5) == 0)
                    c.x_second = 8'(pick_coord(COLS, wx));
                else
                    c.x_second = 8'(int'(c.x_coord) + pick_extent());
            end
            else if (pick < 8)
            begin
                c.x_second = c.x_coord;
                if ($urandom_range(0, 5) == 0)
                    c.y_second = 8'(pick_coord(ROWS, wy));
                else
                    c.y_second = 8'(int'(c.y_coord) + pick_extent());
            end
            else
            begin
                c.x_second = 8'(pick_coord(COLS, wx));
                c.y_second = 8'(pick_coord(ROWS, wy));
            end
        end
        else if (r < 68)
            c.cmd = mpfb_pkg::CMD_RECT;
        else if (r < 76)
        begin
            c.cmd = mpfb_pkg::CMD_CLEAR;
            // never both sides large
            if (c.x_second > 40 && c.y_second > 40)
                c.y_second = 8'($urandom_range(1, 8));
        end
        else if (r < 97)
        begin
            c.cmd = mpfb_pkg::CMD_READ_BYTE;
            pick = $urandom_range(0, 4);
            if (pick == 0)
                c.y_coord = 8'($urandom_range(0, 255));
            else if (pick < 3)
                c.y_coord = 8'($urandom_range(0, PAGES - 1));
            else
                c.y_coord = 8'(wy / 8 + $urandom_range(0, 1));
        end
        else
            c.cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
        return c;
    endfunction

    // Send one command beat and queue its predicted result once accepted
    task automatic send_cmd(mpfb_pkg::req_t c);
        int       gap;
        pending_t p;
        gap = no_stall ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= c;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        p.cmd  = c;
        p.want = predict_command(c);
        pending_results.push_back(p);
        sent++;
        cmd_count[c.cmd]++;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_points();
        send_cmd(make_cmd(mpfb_pkg::CMD_PIXEL_WRITE, 0, 0, 0, 0, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_PIXEL_WRITE, LAST_COL, LAST_ROW, 0, 0, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_PIXEL_READ, 0, 0, 0, 0, 1'b0));
        send_cmd(make_cmd(mpfb_pkg::CMD_PIXEL_READ, LAST_COL, LAST_ROW, 0, 0, 1'b0));
        send_cmd(make_cmd(mpfb_pkg::CMD_PIXEL_WRITE, LAST_COL, LAST_ROW, 8'hFF, 8'hFF, 1'b0));
        send_cmd(make_cmd(mpfb_pkg::CMD_PIXEL_READ, LAST_COL, LAST_ROW, 0, 0, 1'b0));
        // off-screen points are rejected
        send_cmd(make_cmd(mpfb_pkg::CMD_PIXEL_WRITE, COLS, 0, 0, 0, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_PIXEL_READ, 0, ROWS, 0, 0, 1'b0));
        send_cmd(make_cmd(CMD_SPARE_6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_cmd(make_cmd(CMD_SPARE_7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    endtask

    task automatic test_lines();
        send_cmd(make_cmd(mpfb_pkg::CMD_LINE, 0, 10, LAST_COL, 10, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_LINE, 5, 0, 5, 8'hFF, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_LINE, 50, 50, 50, 50, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_LINE, 100, 20, 30, 20, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_LINE, 0, 0, 10, 10, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_LINE, 120, LAST_ROW, 8'hFF, LAST_ROW, 1'b1));
    endtask

    task automatic test_outlines();
        send_cmd(make_cmd(mpfb_pkg::CMD_RECT, 2, 3, 10, 6, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_RECT, 20, 20, 0, 9, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_RECT, 100, 40, 8'hFF, 8'hFF, 1'b1));
    endtask

    task automatic test_clears();
        send_cmd(make_cmd(mpfb_pkg::CMD_READ_BYTE, 5, 0, 0, 0, 1'b0));
        send_cmd(make_cmd(mpfb_pkg::CMD_READ_BYTE, LAST_COL, PAGES - 1, 0, 0, 1'b0));
        send_cmd(make_cmd(mpfb_pkg::CMD_READ_BYTE, COLS, 0, 0, 0, 1'b0));
        send_cmd(make_cmd(mpfb_pkg::CMD_READ_BYTE, 0, PAGES, 0, 0, 1'b0));
        send_cmd(make_cmd(mpfb_pkg::CMD_CLEAR, 0, 8, 64, 8, 1'b1));
        send_cmd(make_cmd(mpfb_pkg::CMD_CLEAR, 0, 0, 5, 0, 1'b0));
        send_cmd(make_cmd(mpfb_pkg::CMD_CLEAR, 0, 0, 8'hFF, 8'hFF, 1'b0));
    endtask

    task automatic test_random_drawing();
        for (int k = 0; k < RANDOM_CHUNKS; k++)
        begin
            wx       = $urandom_range(0, COLS - 16);
            wy       = $urandom_range(0, ROWS - 16);
            no_stall = ($urandom_range(0, 3) == 0);
            repeat (CHUNK_ITEMS)
                send_cmd(random_command());
        end
        no_stall = 1'b0;
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, mpfb_pkg::req_t c, int got, int want);
        if (errors < MAX_REPORTS)
            $display("[%0t] MISMATCH %s: cmd %0d x %0d y %0d x2 %0d y2 %0d v %0d, %s %0d, %s %0d",
                     $time, what, c.cmd, c.x_coord, c.y_coord, c.x_second, c.y_second,
                     c.pixel_value, "got", got, "want", want);
        errors++;
    endtask

    always @(posedge clk)
    begin : result_check
        pending_t p;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no command outstanding", '0, int'(rsp), 0);
            else
            begin
                p = pending_results.pop_front();
                if (rsp.status !== p.want.status)
                    report_mismatch("status", p.cmd, int'(rsp.status),
                                    int'(p.want.status));
                if (rsp.read_data !== p.want.read_data)
                    report_mismatch("read_data", p.cmd, int'(rsp.read_data),
                                    int'(p.want.read_data));
                checked++;
            end
        end
    end

    // Result side backpressure
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (no_stall || $urandom_range(0, 3) != 0)
            rsp_ready <= 1'b1;
        else
        begin
            rsp_ready  <= 1'b0;
            ready_hold <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        foreach (fb_model[i])
            fb_model[i] = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_points();
        test_lines();
        test_outlines();
        test_clears();
        test_random_drawing();

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d pixel writes, %0d pixel reads, %0d lines,",
                 sent, cmd_count[mpfb_pkg::CMD_PIXEL_WRITE],
                 cmd_count[mpfb_pkg::CMD_PIXEL_READ], cmd_count[mpfb_pkg::CMD_LINE]);
        $display("  %0d outlines, %0d clears, %0d byte reads, %0d unknown codes; %0d checked",
                 cmd_count[mpfb_pkg::CMD_RECT], cmd_count[mpfb_pkg::CMD_CLEAR],
                 cmd_count[mpfb_pkg::CMD_READ_BYTE],
                 cmd_count[CMD_SPARE_6] + cmd_count[CMD_SPARE_7], checked);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mpfb_pkg.sv
rtl/mpfb_store.sv
rtl/mpfb_seq.sv
rtl/mono_page_framebuffer_draw_top.sv
dv/tb_mono_page_framebuffer_draw_top.sv
